/* hw/rtl/kmds_pkg.sv */
// Shared types and constants for the key matrix debounce scanner.
`default_nettype none

package kmds_pkg;

   localparam int COLUMN_W    = 4;
   localparam int ROW_FIELD_W = 8;
   localparam int TIME_W      = 32;
   localparam int SETTLE_W    = 16;

   localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd5;

   typedef struct packed {
      logic changed;
      logic stable;
   } lane_result_type;

   typedef struct packed {
      logic [COLUMN_W-1:0]    column;
      logic [ROW_FIELD_W-1:0] changed_mask;
      logic [ROW_FIELD_W-1:0] stable_levels;
   } rsp_data_type;

endpackage

`default_nettype wire

/* hw/rtl/kmds_lane.sv */
// One row lane: per-column raw level, change time and debounced level of one key row.
`default_nettype none

module kmds_lane
   import kmds_pkg::*;
#(
   parameter int COLS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            write_en,
   input  wire logic [(COLS > 1 ? $clog2(COLS) : 1)-1:0] col_idx,
   input  wire logic                            level,
   input  wire logic [TIME_W-1:0]               now_ms,
   input  wire logic [SETTLE_W-1:0]             settle_time_ms,
   output lane_result_type                      result
);

   logic [COLS-1:0]   raw_ff;
   logic [COLS-1:0]   deb_ff;
   logic [COLS-1:0]   time_valid_ff;
   logic [TIME_W-1:0] time_ff [COLS];

   logic              raw_prev;
   logic              deb_prev;
   logic              raw_change;
   logic [TIME_W-1:0] stored_time;
   logic [TIME_W-1:0] elapsed;
   logic              settled;
   logic              deb_in;

   always_comb begin
      raw_prev    = raw_ff[col_idx];
      deb_prev    = deb_ff[col_idx];
      stored_time = time_valid_ff[col_idx] ? time_ff[col_idx] : '0;
      raw_change  = raw_prev != level;
      elapsed     = raw_change ? '0 : (now_ms - stored_time);
      settled     = elapsed >= TIME_W'(settle_time_ms);
      deb_in      = settled ? level : deb_prev;
      result.changed = deb_in != deb_prev;
      result.stable  = deb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff        <= '0;
         deb_ff        <= '0;
         time_valid_ff <= '0;
      end else if (write_en) begin
         raw_ff[col_idx] <= level;
         deb_ff[col_idx] <= deb_in;
         if (raw_change) begin
            time_valid_ff[col_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write_en && raw_change) begin
         time_ff[col_idx] <= now_ms;
      end
   end

   a_changed_follows_raw: assert property (@(posedge clock) disable iff (reset)
      result.changed |-> result.stable == level)
      else $error("debounced change does not match raw level");

   a_time_restart: assert property (@(posedge clock) disable iff (reset)
      write_en && raw_change |=> time_valid_ff[$past(col_idx)]
                                 && time_ff[$past(col_idx)] == $past(now_ms))
      else $error("raw change did not restart key timer");

endmodule

`default_nettype wire

/* hw/rtl/kmds_merge.sv */
// Merge stage: gathers lane results into row masks and holds them in an output/skid buffer.
`default_nettype none

module kmds_merge
   import kmds_pkg::*;
#(
   parameter int LANES = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic                   in_range,
   input  wire logic [COLUMN_W-1:0]    column,
   input  wire logic [LANES-1:0]       lane_changed,
   input  wire logic [LANES-1:0]       lane_stable,
   output logic                        accept_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [COLUMN_W-1:0]         rsp_column_out,
   output logic [ROW_FIELD_W-1:0]      rsp_changed_mask,
   output logic [ROW_FIELD_W-1:0]      rsp_stable_levels
);

   rsp_data_type new_data;
   rsp_data_type out_data_ff, out_data_in;
   rsp_data_type skid_data_ff, skid_data_in;
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;

   always_comb begin
      new_data.column        = column;
      new_data.changed_mask  = in_range ? ROW_FIELD_W'(lane_changed) : '0;
      new_data.stable_levels = in_range ? ROW_FIELD_W'(lane_stable) : '0;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_valid_in = 1'b1;
            out_data_in  = new_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         // hold the stalled transfer, park the new one
         skid_valid_in = 1'b1;
         skid_data_in  = new_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign accept_ready      = !skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_column_out    = out_data_ff.column;
   assign rsp_changed_mask  = out_data_ff.changed_mask;
   assign rsp_stable_levels = out_data_ff.stable_levels;

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry did not move to output");

   a_out_of_range_empty: assert property (@(posedge clock) disable iff (reset)
      push && !in_range && (!out_valid_ff || rsp_ready) && !skid_valid_ff
      |=> rsp_changed_mask == '0 && rsp_stable_levels == '0)
      else $error("out-of-range column reported key state");

endmodule

`default_nettype wire

/* hw/rtl/key_matrix_debounce_scanner.sv */
// Top level of the keyboard matrix scanner with per-key debounce.
//
// Usage: each transfer on the req_ channel carries one column sample: the
// driven column, the row levels sensed on it and the current millisecond
// time. Each sample yields exactly one transfer on the rsp_ channel with the
// column, the mask of keys whose debounced level changed and the debounced
// levels of that column after the sample (both zero for a column index at or beyond COLS).
// The result is registered in the output entry, first in the skid entry if the receiver
// stalls. One sample is taken every cycle while req_ready is high; each row of the column,
// up to ROW_FIELD_W rows, is handled by its own lane. When the receiver stalls, one more
// sample is taken into a skid entry and req_ready then drops until the receiver drains it;
// no result is lost. csr_wr_en writes settle_time_ms in the cycle it is high; write it only
// while no sample is in flight.
// Synchronous reset clears raw levels, debounced levels and key timers to
// zero, sets settle_time_ms to 5 and empties the output buffer.
`default_nettype none

module key_matrix_debounce_scanner
   import kmds_pkg::*;
#(
   parameter int ROWS = 8,
   parameter int COLS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [COLUMN_W-1:0]    req_column_index,
   input  wire logic [ROW_FIELD_W-1:0] req_row_levels,
   input  wire logic [TIME_W-1:0]      req_now_ms,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [COLUMN_W-1:0]         rsp_column_out,
   output logic [ROW_FIELD_W-1:0]      rsp_changed_mask,
   output logic [ROW_FIELD_W-1:0]      rsp_stable_levels,
   input  wire logic                   csr_wr_en,
   input  wire logic [SETTLE_W-1:0]    csr_wr_data
);

   localparam int LANES = (ROWS < ROW_FIELD_W) ? ROWS : ROW_FIELD_W;
   localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int IDX_W = (COL_W > COLUMN_W) ? COL_W : COLUMN_W;

   logic [SETTLE_W-1:0] settle_time_ms_ff;
   logic                push;
   logic                in_range;
   logic                write_en;
   logic [IDX_W-1:0]    col_ext;
   logic [COL_W-1:0]    col_idx;
   lane_result_type     lane_res [LANES];
   logic [LANES-1:0]    lane_changed;
   logic [LANES-1:0]    lane_stable;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_time_ms_ff <= SETTLE_RESET;
      end else if (csr_wr_en) begin
         settle_time_ms_ff <= csr_wr_data;
      end
   end

   assign push     = req_valid && req_ready;
   assign in_range = int'(req_column_index) < COLS;
   assign write_en = push && in_range;
   assign col_ext  = IDX_W'(req_column_index);
   assign col_idx  = col_ext[COL_W-1:0];

   for (genvar r = 0; r < LANES; r++) begin : g_lane
      kmds_lane #(
         .COLS(COLS)
      ) u_lane (
         .clock          (clock),
         .reset          (reset),
         .write_en       (write_en),
         .col_idx        (col_idx),
         .level          (req_row_levels[r]),
         .now_ms         (req_now_ms),
         .settle_time_ms (settle_time_ms_ff),
         .result         (lane_res[r])
      );
      assign lane_changed[r] = lane_res[r].changed;
      assign lane_stable[r]  = lane_res[r].stable;
   end

   kmds_merge #(
      .LANES(LANES)
   ) u_merge (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .in_range          (in_range),
      .column            (req_column_index),
      .lane_changed      (lane_changed),
      .lane_stable       (lane_stable),
      .accept_ready      (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_column_out    (rsp_column_out),
      .rsp_changed_mask  (rsp_changed_mask),
      .rsp_stable_levels (rsp_stable_levels)
   );

endmodule

`default_nettype wire
